// ----- sv/assert_macros.svh -----
// Assertion helpers shared by the tokenizer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside reset.
`define QAT_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check on every clock edge, reset included.
`define QAT_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- sv/qat_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// qat_pkg
// Types, codes and constants of the quoted argument tokenizer.
// ---------------------------------------------------------------------------
package qat_pkg;

  localparam int QAT_QUEUE_DEPTH = 4;
  localparam int MAX_RESULTS     = 4;

  localparam logic [7:0] CHR_HASH   = 8'h23;
  localparam logic [7:0] CHR_QUOTE  = 8'h22;
  localparam logic [7:0] CHR_LBRACK = 8'h5B;
  localparam logic [7:0] CHR_RBRACK = 8'h5D;
  localparam logic [7:0] SEP_MAX    = 8'd32;

  localparam logic [1:0] KIND_BYTE     = 2'd0;
  localparam logic [1:0] KIND_BOUNDARY = 2'd1;
  localparam logic [1:0] KIND_EOL      = 2'd2;

  localparam logic [2:0] MODE_BEFORE  = 3'd0;
  localparam logic [2:0] MODE_WORD    = 3'd1;
  localparam logic [2:0] MODE_QUOTED  = 3'd2;
  localparam logic [2:0] MODE_BRACKET = 3'd3;
  localparam logic [2:0] MODE_DROP    = 3'd4;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_line;
  } item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] value;
    logic       last_of_run;
  } result_t;

  typedef struct packed {
    logic [2:0]                   count;
    result_t [MAX_RESULTS-1:0]    slot;
  } bundle_t;

endpackage

// ----- sv/qat_front.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// qat_front
// Classifies each byte against the scan mode and builds the bundle of
// results it causes.
// ---------------------------------------------------------------------------
module qat_front import qat_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    accept,
  input  item_t   item,
  output logic    wr,
  output bundle_t bundle
);

  logic [2:0] scan_mode;
  logic       quote_pending;
  logic [2:0] scan_mode_next;
  logic       quote_pending_next;
  logic [2:0] n;
  logic       consumed;
  logic [7:0] b;

  function automatic result_t mk(input logic [1:0] k, input logic [7:0] v);
    result_t r;
    r.kind        = k;
    r.value       = (k == KIND_BYTE) ? v : 8'd0;
    r.last_of_run = 1'b0;
    return r;
  endfunction

  always_comb begin
    b                  = item.in_byte;
    scan_mode_next     = scan_mode;
    quote_pending_next = quote_pending;
    n                  = 3'd0;
    consumed           = 1'b0;
    bundle             = '0;

    if (scan_mode == MODE_QUOTED && quote_pending) begin
      quote_pending_next = 1'b0;
      if (b == CHR_QUOTE) begin
        bundle.slot[n[1:0]] = mk(KIND_BYTE, CHR_QUOTE);
        n = n + 3'd1;
        consumed = 1'b1;
      end else begin
        bundle.slot[n[1:0]] = mk(KIND_BOUNDARY, 8'd0);
        n = n + 3'd1;
        scan_mode_next = MODE_BEFORE;
      end
    end

    if (!consumed) begin
      case (scan_mode_next)
        MODE_WORD: begin
          if (b <= SEP_MAX) begin
            bundle.slot[n[1:0]] = mk(KIND_BOUNDARY, 8'd0);
            n = n + 3'd1;
            scan_mode_next = MODE_BEFORE;
          end else begin
            bundle.slot[n[1:0]] = mk(KIND_BYTE, b);
            n = n + 3'd1;
          end
        end
        MODE_QUOTED: begin
          if (b == CHR_QUOTE) begin
            quote_pending_next = 1'b1;
          end else begin
            bundle.slot[n[1:0]] = mk(KIND_BYTE, b);
            n = n + 3'd1;
          end
        end
        MODE_BRACKET: begin
          if (b == CHR_RBRACK) begin
            bundle.slot[n[1:0]] = mk(KIND_BOUNDARY, 8'd0);
            n = n + 3'd1;
            scan_mode_next = MODE_BEFORE;
          end else begin
            bundle.slot[n[1:0]] = mk(KIND_BYTE, b);
            n = n + 3'd1;
          end
        end
        MODE_DROP: begin
        end
        default: begin
          scan_mode_next = MODE_BEFORE;
          if (b > SEP_MAX) begin
            if (b == CHR_HASH) begin
              scan_mode_next = MODE_DROP;
            end else if (b == CHR_QUOTE) begin
              scan_mode_next     = MODE_QUOTED;
              quote_pending_next = 1'b0;
            end else if (b == CHR_LBRACK) begin
              scan_mode_next = MODE_BRACKET;
            end else begin
              scan_mode_next = MODE_WORD;
              bundle.slot[n[1:0]] = mk(KIND_BYTE, b);
              n = n + 3'd1;
            end
          end
        end
      endcase
    end

    if (item.end_of_line) begin
      if (scan_mode_next inside {MODE_WORD, MODE_QUOTED, MODE_BRACKET}) begin
        bundle.slot[n[1:0]] = mk(KIND_BOUNDARY, 8'd0);
        n = n + 3'd1;
      end
      bundle.slot[n[1:0]] = mk(KIND_EOL, 8'd0);
      n = n + 3'd1;
      scan_mode_next     = MODE_BEFORE;
      quote_pending_next = 1'b0;
    end

    if (n != 3'd0) begin
      bundle.slot[2'(n - 3'd1)].last_of_run = 1'b1;
    end
    bundle.count = n;
  end

  assign wr = accept && (n != 3'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode     <= MODE_BEFORE;
      quote_pending <= 1'b0;
    end else if (accept) begin
      scan_mode     <= scan_mode_next;
      quote_pending <= quote_pending_next;
    end
  end

endmodule

// ----- sv/qat_queue.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// qat_queue
// Short queue of result bundles between the classifier and the sequencer.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module qat_queue import qat_pkg::*; #(
  parameter int DEPTH = QAT_QUEUE_DEPTH
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    wr,
  input  bundle_t wr_data,
  input  logic    rd,
  output bundle_t head,
  output logic    valid,
  output logic    full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  bundle_t          mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign valid = (count != '0);
  assign full  = (count == CNT_FULL);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (rd) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({wr, rd})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  `QAT_ASSERT(a_no_write_full, clk, rst, !(wr && full), "write into full queue")
  `QAT_ASSERT(a_no_read_empty, clk, rst, !(rd && !valid), "read from empty queue")
  `QAT_ASSERT_ALWAYS(a_count_range, clk, rst || (count <= CNT_FULL), "queue count out of range")

endmodule

// ----- sv/qat_back.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// qat_back
// Steps through the results of the head bundle, one transaction per pop.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module qat_back import qat_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  bundle_t head,
  input  logic    head_valid,
  input  logic    pop,
  output logic    empty,
  output result_t result,
  output logic    deq
);

  logic [1:0] idx;
  logic       take;

  assign empty  = !head_valid;
  assign result = head.slot[idx];
  assign take   = pop && head_valid;
  assign deq    = take && result.last_of_run;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= 2'd0;
    end else if (deq) begin
      idx <= 2'd0;
    end else if (take) begin
      idx <= idx + 2'd1;
    end
  end

  `QAT_ASSERT(a_idx_in_bundle, clk, rst,
    head_valid |-> ({1'b0, idx} < head.count), "result index past bundle count")
  `QAT_ASSERT(a_last_matches, clk, rst,
    head_valid |-> (result.last_of_run == ({1'b0, idx} == head.count - 3'd1)),
    "last mark disagrees with bundle count")
  `QAT_ASSERT(a_idx_advance, clk, rst,
    (take && !deq) |=> (idx == $past(idx) + 2'd1), "result index did not advance")

endmodule

// ----- sv/quoted_argument_tokenizer.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// quoted_argument_tokenizer
// Splits a byte stream into argument tokens: plain words, quoted tokens
// with doubled-quote escapes, bracketed tokens and '#' comments.
// ---------------------------------------------------------------------------
//  channel  | handshake          | payload
//  ---------+--------------------+-------------------------------
//  input    | push / full        | item   : in_byte, end_of_line
//  result   | pop / empty        | result : kind, value, last_of_run
//
//  One byte is accepted per cycle while full is low; the classifier needs the scan mode and the pending-quote flag.
//  Each byte yields zero to four results, delivered one per cycle by the
//  sequencer while pop is high and the queue is not empty.
//  A byte's results are registered in the bundle queue and show once their bundle reaches its head.
//  full rises when the bundle queue holds QUEUE_DEPTH entries.
//  Synchronous reset empties the queue and returns to the between-tokens mode.
// ---------------------------------------------------------------------------
module quoted_argument_tokenizer import qat_pkg::*; #(
  parameter int QUEUE_DEPTH = QAT_QUEUE_DEPTH
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  output logic    full,
  input  item_t   item,
  input  logic    pop,
  output logic    empty,
  output result_t result
);

  logic    accept;
  logic    wr;
  bundle_t wr_data;
  bundle_t head;
  logic    head_valid;
  logic    deq;

  assign accept = push && !full;

  qat_front u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (item),
    .wr     (wr),
    .bundle (wr_data)
  );

  qat_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (wr),
    .wr_data (wr_data),
    .rd      (deq),
    .head    (head),
    .valid   (head_valid),
    .full    (full)
  );

  qat_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .empty      (empty),
    .result     (result),
    .deq        (deq)
  );

endmodule
